### sv/bcd_pkg.sv
// Shared types and constants of the block cache directory.
package bcd_pkg;

    localparam int SLOT_W  = 4;
    localparam int BLOCK_W = 32;

    // Action codes carried by an input beat
    localparam logic [1:0] ACT_READ  = 2'd0;
    localparam logic [1:0] ACT_WRITE = 2'd1;
    localparam logic [1:0] ACT_FLUSH = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Kind of command after classification by the front end
    typedef enum logic [1:0] {
        KIND_READ,
        KIND_WRITE,
        KIND_FLUSH
    } kind_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RESOLVE,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        logic [1:0]         action;
        logic [BLOCK_W-1:0] block_number;
    } in_beat_t;

    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               hit;
        logic               fetch_needed;
        logic               writeback;
        logic [BLOCK_W-1:0] writeback_block;
        logic               last;
    } out_beat_t;

    typedef struct packed {
        kind_t              kind;
        logic [BLOCK_W-1:0] block;
    } cmd_t;

endpackage

### sv/block_cache_directory.sv
// Top level of the block cache directory.
//
//  channel   handshake          payload                 beat
//  input     push / full        item   (in_beat_t)      one access, flush or none
//  result    pop / empty        result (out_beat_t)     one slot report
//
// In the back end a read or write access is popped in ST_IDLE, which registers
// the parallel tag match, and is then resolved and updated in ST_RESOLVE.
// A flush is popped in ST_IDLE and then walks the slots in ST_FLUSH, from slot 0 up to
// the last dirty one (slot 0 alone when nothing is dirty).
// Reset clears valid and dirty bits and the replacement pointer; no clearing pass.
// A full result queue stalls the back end; the command queue keeps the front moving.
module block_cache_directory #(
    parameter int SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    output logic               full,
    input  bcd_pkg::in_beat_t  item,
    input  logic               pop,
    output logic               empty,
    output bcd_pkg::out_beat_t result
);

    localparam int QDEPTH = 2;

    bcd_pkg::cmd_t      front_cmd, queue_cmd;
    logic               front_push, cmd_full, cmd_empty, cmd_pop;
    bcd_pkg::out_beat_t back_result;
    logic               res_push, res_full;

    bcd_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .push     (push),
        .full     (full),
        .cmd      (front_cmd),
        .cmd_push (front_push),
        .cmd_full (cmd_full)
    );

    // Command queue between front and back
    bcd_fifo #(
        .WIDTH ($bits(bcd_pkg::cmd_t)),
        .DEPTH (QDEPTH)
    ) u_cmd_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (front_push),
        .wr_data (front_cmd),
        .full    (cmd_full),
        .rd_en   (cmd_pop),
        .rd_data (queue_cmd),
        .empty   (cmd_empty)
    );

    bcd_back #(
        .SLOTS (SLOTS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (queue_cmd),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .result    (back_result),
        .res_push  (res_push),
        .res_full  (res_full)
    );

    // Result queue toward the consumer
    bcd_fifo #(
        .WIDTH ($bits(bcd_pkg::out_beat_t)),
        .DEPTH (QDEPTH)
    ) u_res_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (back_result),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (result),
        .empty   (empty)
    );

endmodule

### sv/bcd_fifo.sv
// Small synchronous FIFO used for the command queue and the result queue.
module bcd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    // Pointer and occupancy update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_rd)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### sv/bcd_front.sv
// Front end: accepts input beats, classifies the action, feeds the command queue.
module bcd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  bcd_pkg::in_beat_t item,
    input  logic              push,
    output logic              full,
    output bcd_pkg::cmd_t     cmd,
    output logic              cmd_push,
    input  logic              cmd_full
);

    logic          valid_reg, valid_next;
    bcd_pkg::cmd_t cmd_reg, cmd_next;
    logic          accept, move, keep;

    assign full     = valid_reg && cmd_full;
    assign accept   = push && !full;
    assign move     = valid_reg && !cmd_full;
    assign cmd_push = move;
    assign cmd      = cmd_reg;

    // Classify the action; the unused code is dropped here
    always_comb
    begin
        cmd_next.block = item.block_number;
        cmd_next.kind  = bcd_pkg::KIND_READ;
        keep           = 1'b1;
        unique case (item.action)
            bcd_pkg::ACT_READ:  cmd_next.kind = bcd_pkg::KIND_READ;
            bcd_pkg::ACT_WRITE: cmd_next.kind = bcd_pkg::KIND_WRITE;
            bcd_pkg::ACT_FLUSH: cmd_next.kind = bcd_pkg::KIND_FLUSH;
            default:            keep          = 1'b0;
        endcase
    end

    // Holding register occupancy
    always_comb
    begin
        valid_next = valid_reg;
        if (move)
        begin
            valid_next = 1'b0;
        end
        if (accept && keep)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && keep)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule

### sv/bcd_back.sv
// Back end: tag directory, lookup and replacement, and the flush walk.
module bcd_back #(
    parameter int SLOTS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bcd_pkg::cmd_t      cmd,
    input  logic               cmd_empty,
    output logic               cmd_pop,
    output bcd_pkg::out_beat_t result,
    output logic               res_push,
    input  logic               res_full
);

    localparam int IW = $clog2(SLOTS);

    bcd_pkg::state_t           state_reg, state_next;
    bcd_pkg::cmd_t             cur_reg;
    logic [SLOTS-1:0]          match_reg, match_now;
    logic [bcd_pkg::BLOCK_W-1:0] tag_reg [SLOTS];
    logic [SLOTS-1:0]          valid_reg, valid_next;
    logic [SLOTS-1:0]          dirty_reg, dirty_next;
    logic [IW-1:0]             ptr_reg, ptr_next;
    logic [IW-1:0]             idx_reg, idx_next;

    logic                      hit, has_empty, evict;
    logic [IW-1:0]             hit_idx, empty_idx, victim, sel_idx;
    logic [SLOTS-1:0]          pend;
    logic                      cur_pend, more, flush_step;

    // Parallel tag compare against the queue head
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            match_now[i] = valid_reg[i] && (tag_reg[i] == cmd.block);
        end
    end

    // Lowest matching slot and lowest empty slot
    always_comb
    begin
        hit_idx   = '0;
        empty_idx = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
        begin
            if (match_reg[i])
            begin
                hit_idx = IW'(i);
            end
            if (!valid_reg[i])
            begin
                empty_idx = IW'(i);
            end
        end
    end

    assign hit       = |match_reg;
    assign has_empty = ~&valid_reg;
    assign evict     = !hit && !has_empty;
    assign victim    = (ptr_reg == IW'(SLOTS - 1)) ? '0 : ptr_reg + 1'b1;
    assign sel_idx   = hit ? hit_idx : (has_empty ? empty_idx : victim);

    // Flush walk: dirty slot here, and any dirty slot further up
    assign pend     = valid_reg & dirty_reg;
    assign cur_pend = pend[idx_reg];
    always_comb
    begin
        more = 1'b0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (pend[i] && (IW'(i) > idx_reg))
            begin
                more = 1'b1;
            end
        end
    end
    assign flush_step = !cur_pend || !res_full;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            bcd_pkg::ST_IDLE:
            begin
                if (!cmd_empty)
                begin
                    state_next = (cmd.kind == bcd_pkg::KIND_FLUSH) ?
                                 bcd_pkg::ST_FLUSH : bcd_pkg::ST_RESOLVE;
                end
            end
            bcd_pkg::ST_RESOLVE:
            begin
                if (!res_full)
                begin
                    state_next = bcd_pkg::ST_IDLE;
                end
            end
            bcd_pkg::ST_FLUSH:
            begin
                if (flush_step && !more)
                begin
                    state_next = bcd_pkg::ST_IDLE;
                end
            end
            default: state_next = bcd_pkg::ST_IDLE;
        endcase
    end

    // Outputs: queue pops and result beats
    always_comb
    begin
        cmd_pop  = 1'b0;
        res_push = 1'b0;
        result   = '0;
        unique case (state_reg)
            bcd_pkg::ST_IDLE:
            begin
                cmd_pop = !cmd_empty;
            end
            bcd_pkg::ST_RESOLVE:
            begin
                res_push               = !res_full;
                result.slot            = bcd_pkg::SLOT_W'(sel_idx);
                result.hit             = hit;
                result.fetch_needed    = !hit && (cur_reg.kind == bcd_pkg::KIND_READ);
                result.writeback       = evict;
                result.writeback_block = evict ? tag_reg[victim] : '0;
                result.last            = 1'b1;
            end
            bcd_pkg::ST_FLUSH:
            begin
                res_push               = cur_pend && !res_full;
                result.slot            = bcd_pkg::SLOT_W'(idx_reg);
                result.writeback       = 1'b1;
                result.writeback_block = tag_reg[idx_reg];
                result.last            = !more;
            end
            default:
            begin
                res_push = 1'b0;
            end
        endcase
    end

    // Directory state update
    always_comb
    begin
        valid_next = valid_reg;
        dirty_next = dirty_reg;
        ptr_next   = ptr_reg;
        idx_next   = idx_reg;
        if (state_reg == bcd_pkg::ST_IDLE)
        begin
            idx_next = '0;
        end
        if ((state_reg == bcd_pkg::ST_RESOLVE) && res_push)
        begin
            if (!hit)
            begin
                valid_next[sel_idx] = 1'b1;
            end
            if (evict)
            begin
                ptr_next            = victim;
                dirty_next[sel_idx] = 1'b0;
            end
            if (cur_reg.kind == bcd_pkg::KIND_WRITE)
            begin
                dirty_next[sel_idx] = 1'b1;
            end
        end
        if (state_reg == bcd_pkg::ST_FLUSH)
        begin
            if (res_push)
            begin
                dirty_next[idx_reg] = 1'b0;
            end
            if (flush_step && more)
            begin
                idx_next = idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bcd_pkg::ST_IDLE;
            valid_reg <= '0;
            dirty_reg <= '0;
            ptr_reg   <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            dirty_reg <= dirty_next;
            ptr_reg   <= ptr_next;
            idx_reg   <= idx_next;
        end
    end

    // Command capture, registered match vector and tag writes
    always_ff @(posedge clk)
    begin
        if (cmd_pop)
        begin
            cur_reg   <= cmd;
            match_reg <= match_now;
        end
        if ((state_reg == bcd_pkg::ST_RESOLVE) && res_push && !hit)
        begin
            tag_reg[sel_idx] <= cur_reg.block;
        end
    end

endmodule
